// ----- rtl/fucf_pkg.sv -----
// Package for the flow update change filter: table geometry, entry and item
// types, and the control structs passed between the controller and the table.
// No dependencies.
`timescale 1ns / 1ps

package fucf_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int SLOT_W        = 12;

	localparam logic [7:0] TCP_PROTOCOL = 8'd6;

	localparam int S_DATA_W = 160;
	localparam int S_USER_W = 8;
	localparam int M_DATA_W = 176;
	localparam int M_USER_W = 2;

	typedef struct packed {
		logic [15:0] dst_port;
		logic [15:0] src_port;
		logic [31:0] dst_addr;
		logic [31:0] src_addr;
	} key_t;

	typedef struct packed {
		logic [31:0] denominator;
		logic [31:0] numerator;
	} val_t;

	typedef struct packed {
		val_t val;
		key_t key;
	} entry_t;

	typedef struct packed {
		logic [7:0] protocol;
		val_t       val;
		key_t       key;
	} item_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} wr_req_t;

	typedef struct packed {
		logic              send;
		logic              is_new;
		logic [SLOT_W-1:0] slot;
		key_t              key;
		val_t              val;
	} result_t;

endpackage

// ----- rtl/fucf_table.sv -----
// Flow table storage: one synchronous memory of keys and values with one write
// port and one read port, read data registered. Depends on fucf_pkg.
`timescale 1ns / 1ps

module fucf_table (
	input  logic              clk,
	input  fucf_pkg::rd_req_t rd_req,
	input  fucf_pkg::wr_req_t wr_req,
	output fucf_pkg::entry_t  rd_data
);

	fucf_pkg::entry_t mem [fucf_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem[wr_req.addr] <= wr_req.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd_data <= mem[rd_req.addr];
		end
	end

endmodule

// ----- rtl/fucf_ctrl.sv -----
// Lookup controller: takes one item, scans the occupied entries one per cycle
// for TCP items, decides, and writes back what it sends. Depends on fucf_pkg.
`timescale 1ns / 1ps

module fucf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               flip_direction,
	input  logic               in_valid,
	output logic               in_ready,
	input  fucf_pkg::item_t    in_item,
	input  logic               out_free,
	output logic               res_valid,
	output fucf_pkg::result_t  res,
	output fucf_pkg::rd_req_t  rd_req,
	input  fucf_pkg::entry_t   rd_data,
	output fucf_pkg::wr_req_t  wr_req
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t                         state_q;
	fucf_pkg::key_t                 key_q;
	fucf_pkg::val_t                 val_q;
	logic                           drop_q;
	logic                           hit_q;
	logic                           changed_q;
	logic [fucf_pkg::IDX_W-1:0]     hit_slot_q;
	logic [fucf_pkg::CNT_W-1:0]     idx_q;
	logic [fucf_pkg::CNT_W-1:0]     fill_q;
	logic                           rd_vld_s1;
	logic [fucf_pkg::IDX_W-1:0]     rd_idx_s1;

	logic                           accept;
	logic                           issue;
	logic                           match_now;
	logic                           scan_done;
	logic                           full;
	logic                           commit;
	logic                           send;
	logic                           is_new;
	logic [fucf_pkg::IDX_W-1:0]     new_slot;
	logic [fucf_pkg::IDX_W-1:0]     slot_idx;
	fucf_pkg::key_t                 in_key;

	// Entries are allocated at the first free slot, or slot 0 when full, and never
	// freed, so the valid entries are always the prefix below the fill count.
	assign full     = (fill_q == fucf_pkg::CNT_W'(fucf_pkg::TABLE_ENTRIES));
	assign new_slot = full ? '0 : fill_q[fucf_pkg::IDX_W-1:0];

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		in_key = in_item.key;
		if (flip_direction) begin
			in_key.src_addr = in_item.key.dst_addr;
			in_key.dst_addr = in_item.key.src_addr;
			in_key.src_port = in_item.key.dst_port;
			in_key.dst_port = in_item.key.src_port;
		end
	end

	assign issue     = (state_q == ST_SCAN) && (idx_q != fill_q);
	assign match_now = rd_vld_s1 && (rd_data.key == key_q);
	assign scan_done = (state_q == ST_SCAN) && (match_now || (!issue && !rd_vld_s1));

	assign rd_req.en   = issue;
	assign rd_req.addr = idx_q[fucf_pkg::IDX_W-1:0];

	assign send     = !drop_q && (!hit_q || changed_q);
	assign is_new   = !drop_q && !hit_q;
	assign slot_idx = drop_q ? '0 : (hit_q ? hit_slot_q : new_slot);
	assign commit   = (state_q == ST_COMMIT) && out_free;

	// Writes happen only in the commit cycle and the next item's scan starts
	// later, so a read never overlaps a write to the same entry.
	assign wr_req.en   = commit && send;
	assign wr_req.addr = slot_idx;
	assign wr_req.data = '{val: val_q, key: key_q};

	assign res_valid = commit;
	always_comb begin
		if (drop_q) begin
			res = '0;
		end else begin
			res.send   = send;
			res.is_new = is_new;
			res.slot   = fucf_pkg::SLOT_W'(slot_idx);
			res.key    = key_q;
			res.val    = val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			drop_q    <= 1'b0;
		end else begin
			// A read still in flight when a match ends the scan is discarded.
			rd_vld_s1 <= issue && !match_now;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						hit_q  <= 1'b0;
						drop_q <= (in_item.protocol != fucf_pkg::TCP_PROTOCOL);
						state_q <= (in_item.protocol != fucf_pkg::TCP_PROTOCOL) ?
							ST_COMMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match_now) begin
						hit_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (commit) begin
						if (is_new && !full) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[fucf_pkg::IDX_W-1:0];
		if (accept) begin
			key_q <= in_key;
			val_q <= in_item.val;
		end
		if (match_now) begin
			hit_slot_q <= rd_idx_s1;
			changed_q  <= (rd_data.val != val_q);
		end
	end

endmodule

// ----- rtl/flow_update_change_filter.sv -----
// Top level of the flow update change filter: stream ports, the direction
// register and the output register. Depends on fucf_pkg, fucf_ctrl, fucf_table.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// s_*       in         s_tvalid / s_tready      flow record, protocol in s_tuser
// m_*       out        m_tvalid / m_tready      result, send and is_new in m_tuser
// cfg_*     in         cfg_valid / cfg_ready    flip_direction
//
// One item at a time. The single read port of the table is scanned one entry
// per cycle over the occupied entries (up to 4096), stopping at the first match;
// items that are not TCP skip the scan. Reset empties the table at once through
// the fill count. A result waiting in the output register does not stop the next
// item being taken; only the commit of the following item waits for it.

module flow_update_change_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// src_addr, dst_addr, src_port, dst_port, numerator, denominator
	input  logic [fucf_pkg::S_DATA_W-1:0] s_tdata,
	// protocol
	input  logic [fucf_pkg::S_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// slot, out_src_addr, out_dst_addr, out_src_port, out_dst_port,
	// out_numerator, out_denominator, zero padding
	output logic [fucf_pkg::M_DATA_W-1:0] m_tdata,
	// send, is_new
	output logic [fucf_pkg::M_USER_W-1:0] m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);

	logic               flip_q;
	logic               m_valid_q;
	fucf_pkg::result_t  m_res_q;
	fucf_pkg::item_t    in_item;
	fucf_pkg::result_t  res;
	logic               res_valid;
	logic               out_free;
	fucf_pkg::rd_req_t  rd_req;
	fucf_pkg::wr_req_t  wr_req;
	fucf_pkg::entry_t   rd_data;

	assign cfg_ready = 1'b1;

	assign in_item.key.src_addr        = s_tdata[31:0];
	assign in_item.key.dst_addr        = s_tdata[63:32];
	assign in_item.key.src_port        = s_tdata[79:64];
	assign in_item.key.dst_port        = s_tdata[95:80];
	assign in_item.val.numerator       = s_tdata[127:96];
	assign in_item.val.denominator     = s_tdata[159:128];
	assign in_item.protocol            = s_tuser;

	assign out_free = !m_valid_q || m_tready;

	fucf_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.flip_direction (flip_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_item        (in_item),
		.out_free       (out_free),
		.res_valid      (res_valid),
		.res            (res),
		.rd_req         (rd_req),
		.rd_data        (rd_data),
		.wr_req         (wr_req)
	);

	fucf_table u_table (
		.clk     (clk),
		.rd_req  (rd_req),
		.wr_req  (wr_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q    <= 1'b1;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				flip_q <= cfg_data;
			end
			if (res_valid) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = {m_res_q.is_new, m_res_q.send};
	assign m_tdata  = {4'b0000,
		m_res_q.val.denominator, m_res_q.val.numerator,
		m_res_q.key.dst_port, m_res_q.key.src_port,
		m_res_q.key.dst_addr, m_res_q.key.src_addr,
		m_res_q.slot};

endmodule

// ----- rtl/fucf_chk.sv -----
// Port-level checker for the flow update change filter, bound to the top
// level. Depends on fucf_pkg and flow_update_change_filter.
`timescale 1ns / 1ps

module fucf_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [fucf_pkg::M_DATA_W-1:0] m_tdata,
	input logic [fucf_pkg::M_USER_W-1:0] m_tuser
);

	// A result held back by the sink stays as it is.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// A new key is always forwarded.
	a_new_sends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("new key not marked for sending");

	// A result appears only after the item has left the input side.
	a_res_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while the block was idle");

endmodule

bind flow_update_change_filter fucf_chk u_fucf_chk (.*);
